>>> hdl/lidar_scan_to_world_points_assert.svh
// ----------------------------------------------------------------------------
// Assertion helpers for the lidar scan to world point converter
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_TO_WORLD_POINTS_ASSERT_SVH
`define LIDAR_SCAN_TO_WORLD_POINTS_ASSERT_SVH

// ante must be followed by cons in the same cycle
`define LSTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons holds at every edge out of reset
`define LSTW_ASSERT_ALWAYS(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cons)) else $error(msg);

`endif

>>> hdl/lstw_pkg.sv
// ----------------------------------------------------------------------------
// lstw_pkg
// Shared types, constants and helpers of the lidar scan to world converter.
// ----------------------------------------------------------------------------
package lstw_pkg;

  localparam int SCAN_POINTS = 811;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 112;
  localparam int CFG_INDEX_W = 3;
  localparam int POS_W       = 40;

  typedef logic [15:0]              angle_t;
  typedef logic signed [31:0]       trig_t;
  typedef logic signed [POS_W-1:0]  pos_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_HEADING  = 3'd2,
    CFG_MOUNT    = 3'd3,
    CFG_LEVER    = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] NEAR_LIMIT_MM  = 16'd50;
  localparam logic [15:0] FAR_FILL_MM    = 16'd25000;
  localparam logic [15:0] LEVER_RESET_MM = 16'd1000;

  // theta = (beam*65536 + 540) / 1080 - 24576, divide done by reciprocal
  localparam logic [63:0] THETA_MUL  = ((64'd1 << 38) + 64'd1079) / 64'd1080;
  localparam logic [26:0] THETA_BIAS = 27'd540;
  localparam angle_t      THETA_OFS  = 16'd24576;

  // pi in Q31, one in Q30, octant boundaries in binary angle units
  localparam logic [32:0] PI_Q31   = 33'd6746518852;
  localparam logic [30:0] Q_ONE    = 31'h4000_0000;
  localparam logic [13:0] OCT_HALF = 14'd8192;
  localparam logic [14:0] OCT_FULL = 15'd16384;
  localparam trig_t       TRIG_ONE = 32'sh4000_0000;

  localparam int SIN_CELLS = 5;
  localparam int COS_CELLS = 6;
  localparam int SIN_DIV [SIN_CELLS] = '{110, 72, 42, 20, 6};
  localparam int COS_DIV [COS_CELLS] = '{132, 90, 56, 30, 12, 2};

  // reduce, scale, square, cell chain, select
  localparam int SC_LAT = 2 * COS_CELLS + 4;

  // mag times Q30 factor, rounded to nearest mm, ties toward +inf
  function automatic logic signed [18:0] scale_round(input logic [15:0] mag, input trig_t f);
    logic signed [48:0] p;
    p = $signed({1'b0, mag}) * f;
    p = p + 49'sd536870912;
    return p[48:30];
  endfunction

endpackage

>>> hdl/lidar_scan_to_world_points.sv
// ----------------------------------------------------------------------------
// lidar_scan_to_world_points
// Converts lidar range samples with beam index into world x/y in millimetres.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sample per transfer; tdata carries range and beam index,
//           tuser flags a sample with no return.
//   out_* : one point per sample, in input order: world x, world y, the
//           filtered range and the beam index as received.
//   cfg_* : register writes (origin x/y, heading, mount offset, lever arm),
//           always ready; write them only while no sample is in flight.
//   Throughput is one sample per clock while the output stage has room. Its
//   pipeline depth is set mostly by the sine and cosine cell chains
//   (two-stage Taylor cells, six in the longer cosine chain) plus the
//   reciprocal divide for the beam angle and the rounding multipliers.
//   When out_tready is low, a two-entry output stage keeps taking results;
//   once its second entry fills, in_tready drops and the whole pipeline
//   holds until the receiver takes a result.
//   Synchronous reset clears the pipeline, the output stage and restores the
//   registers (origin 0, heading 0, mount offset 0, lever arm 1000 mm).
// ----------------------------------------------------------------------------
`include "lidar_scan_to_world_points_assert.svh"

module lidar_scan_to_world_points #(
  parameter int SCAN_POINTS = lstw_pkg::SCAN_POINTS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: [15:0] range_mm, [25:16] beam_index, rest zero
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lstw_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: [0] range_infinite
  input  logic                                 in_tuser,
  // out_tdata: [39:0] point_x_mm, [79:40] point_y_mm,
  //            [95:80] filtered_range_mm, [105:96] echo_index, rest zero
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lstw_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lstw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lstw_pkg::POS_W-1:0]           cfg_data
);

  localparam int LAT = lstw_pkg::SC_LAT;

  // configuration
  lstw_pkg::pos_t   origin_x_r;
  lstw_pkg::pos_t   origin_y_r;
  lstw_pkg::angle_t heading_r;
  lstw_pkg::angle_t mount_r;
  logic [15:0]      lever_r;

  logic pipe_en;
  logic in_xfer;

  logic [15:0] rng_in;
  logic [9:0]  beam_in;
  logic [15:0] rng_nxt;
  logic [9:0]  beam_nxt;

  logic        p0_vld_r;
  logic [15:0] p0_rng_r;
  logic [9:0]  p0_beam_r;
  logic [9:0]  p0_idx_r;

  logic [26:0] th_num;
  logic [54:0] th_prod;
  logic        p1_vld_r;
  logic [15:0] p1_rng_r;
  logic [9:0]  p1_idx_r;
  lstw_pkg::angle_t p1_theta_r;

  logic        p2_vld_r;
  logic [15:0] p2_rng_r;
  logic [9:0]  p2_idx_r;
  lstw_pkg::angle_t p2_phi_r;

  logic        vld_d_r [LAT];
  logic [15:0] rng_d_r [LAT];
  logic [9:0]  idx_d_r [LAT];

  lstw_pkg::trig_t ps_w;
  lstw_pkg::trig_t pc_w;
  lstw_pkg::trig_t hs_w;
  lstw_pkg::trig_t hc_w;

  logic               p3_vld_r;
  logic [15:0]        p3_rng_r;
  logic [9:0]         p3_idx_r;
  logic signed [18:0] lx_r;
  logic signed [18:0] ly_r;
  logic signed [18:0] rx_r;
  logic signed [18:0] ry_r;

  lstw_pkg::pos_t x_sum;
  lstw_pkg::pos_t y_sum;
  logic [lstw_pkg::OUT_TDATA_W-1:0] res_pack;

  logic                             out_valid_r;
  logic [lstw_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                             sk_valid_r;
  logic [lstw_pkg::OUT_TDATA_W-1:0] sk_data_r;

  logic        out_stall;
  logic [15:0] out_rng;
  logic        trig_ok;

  // pipeline moves while the skid entry is free
  assign pipe_en   = !sk_valid_r;
  assign in_tready = pipe_en;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      heading_r  <= '0;
      mount_r    <= '0;
      lever_r    <= lstw_pkg::LEVER_RESET_MM;
    end else if (cfg_valid && cfg_ready) begin
      case (lstw_pkg::cfg_reg_t'(cfg_index))
        lstw_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
        lstw_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        lstw_pkg::CFG_HEADING:  heading_r  <= cfg_data[15:0];
        lstw_pkg::CFG_MOUNT:    mount_r    <= cfg_data[15:0];
        lstw_pkg::CFG_LEVER:    lever_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- input filtering ----------------
  assign rng_in  = in_tdata[15:0];
  assign beam_in = in_tdata[25:16];

  always_comb begin
    if (in_tuser || (rng_in < lstw_pkg::NEAR_LIMIT_MM)) begin
      rng_nxt = lstw_pkg::FAR_FILL_MM;
    end else begin
      rng_nxt = rng_in;
    end
    // beams past the end of the scan use the last beam angle
    if ({22'd0, beam_in} > 32'(SCAN_POINTS - 1)) begin
      beam_nxt = 10'(SCAN_POINTS - 1);
    end else begin
      beam_nxt = beam_in;
    end
  end

  // beam angle: reciprocal multiply replaces the divide by 1080
  assign th_num  = {1'b0, p0_beam_r, 16'd0} + lstw_pkg::THETA_BIAS;
  assign th_prod = 55'(th_num) * 55'(lstw_pkg::THETA_MUL[27:0]);

  // ---------------- trig units ----------------
  lstw_sincos u_sc_phi (
    .clk     (clk),
    .en      (pipe_en),
    .angle_i (p2_phi_r),
    .sin_o   (ps_w),
    .cos_o   (pc_w)
  );

  lstw_sincos u_sc_head (
    .clk     (clk),
    .en      (pipe_en),
    .angle_i (heading_r),
    .sin_o   (hs_w),
    .cos_o   (hc_w)
  );

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      for (int i = 0; i < LAT; i++) begin
        vld_d_r[i] <= 1'b0;
      end
    end else if (pipe_en) begin
      p0_vld_r   <= in_xfer;
      p1_vld_r   <= p0_vld_r;
      p2_vld_r   <= p1_vld_r;
      vld_d_r[0] <= p2_vld_r;
      for (int i = 1; i < LAT; i++) begin
        vld_d_r[i] <= vld_d_r[i-1];
      end
      p3_vld_r <= vld_d_r[LAT-1];
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p0_rng_r   <= rng_nxt;
      p0_beam_r  <= beam_nxt;
      p0_idx_r   <= beam_in;
      p1_rng_r   <= p0_rng_r;
      p1_idx_r   <= p0_idx_r;
      p1_theta_r <= th_prod[53:38] - lstw_pkg::THETA_OFS;
      p2_rng_r   <= p1_rng_r;
      p2_idx_r   <= p1_idx_r;
      p2_phi_r   <= heading_r + mount_r + p1_theta_r;
      rng_d_r[0] <= p2_rng_r;
      idx_d_r[0] <= p2_idx_r;
      for (int i = 1; i < LAT; i++) begin
        rng_d_r[i] <= rng_d_r[i-1];
        idx_d_r[i] <= idx_d_r[i-1];
      end
      p3_rng_r <= rng_d_r[LAT-1];
      p3_idx_r <= idx_d_r[LAT-1];
      lx_r     <= lstw_pkg::scale_round(lever_r, hc_w);
      ly_r     <= lstw_pkg::scale_round(lever_r, hs_w);
      rx_r     <= lstw_pkg::scale_round(rng_d_r[LAT-1], pc_w);
      ry_r     <= lstw_pkg::scale_round(rng_d_r[LAT-1], ps_w);
    end
  end

  // sums wrap at 40 bits
  assign x_sum    = origin_x_r + lstw_pkg::pos_t'(lx_r) + lstw_pkg::pos_t'(rx_r);
  assign y_sum    = origin_y_r + lstw_pkg::pos_t'(ly_r) + lstw_pkg::pos_t'(ry_r);
  assign res_pack = {6'd0, p3_idx_r, p3_rng_r, y_sum, x_sum};

  // ---------------- output register with skid entry ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (pipe_en) begin
      if (out_valid_r && !out_tready) begin
        sk_valid_r <= p3_vld_r;
      end else begin
        out_valid_r <= p3_vld_r;
      end
    end else if (out_tready) begin
      sk_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      if (out_valid_r && !out_tready) begin
        sk_data_r <= res_pack;
      end else begin
        out_data_r <= res_pack;
      end
    end else if (out_tready) begin
      out_data_r <= sk_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  assign out_stall = out_valid_r && !out_tready;
  assign out_rng   = out_data_r[95:80];
  assign trig_ok   = (ps_w <= lstw_pkg::TRIG_ONE) && (ps_w >= -lstw_pkg::TRIG_ONE) &&
                     (pc_w <= lstw_pkg::TRIG_ONE) && (pc_w >= -lstw_pkg::TRIG_ONE) &&
                     (hs_w <= lstw_pkg::TRIG_ONE) && (hs_w >= -lstw_pkg::TRIG_ONE) &&
                     (hc_w <= lstw_pkg::TRIG_ONE) && (hc_w >= -lstw_pkg::TRIG_ONE);

  `LSTW_ASSERT_ALWAYS(a_skid_has_head, !sk_valid_r || out_valid_r, "skid full, output empty")
  `LSTW_ASSERT_IMP(a_skid_fill, $rose(sk_valid_r), $past(out_stall), "skid filled w/o stall")
  `LSTW_ASSERT_IMP(a_range_floor, out_valid_r, out_rng >= lstw_pkg::NEAR_LIMIT_MM, "range low")
  `LSTW_ASSERT_IMP(a_trig_bound, vld_d_r[LAT-1], trig_ok, "trig value beyond unit magnitude")

endmodule

>>> hdl/lstw_horner_cell.sv
// ----------------------------------------------------------------------------
// lstw_horner_cell
// One nested Taylor step: t_o = 1 - ((x2 * t_i) >> 30) / K in Q30, two stages.
// ----------------------------------------------------------------------------
module lstw_horner_cell #(
  parameter int K = 2
) (
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] x2_i,
  input  logic [30:0] t_i,
  output logic [29:0] x2_o,
  output logic [30:0] t_o
);

  // exact floor(v / K) for v < 2^30 via rounded-up reciprocal
  localparam int          L   = $clog2(K);
  localparam logic [63:0] MUL = ((64'd1 << (30 + L)) + 64'(K) - 64'd1) / 64'(K);

  logic [60:0] prod;
  logic [60:0] qprod;
  logic [29:0] quo;
  logic [29:0] v_r;
  logic [29:0] x2_d_r;
  logic [30:0] t_r;
  logic [29:0] x2_o_r;

  assign prod  = 61'(x2_i) * 61'(t_i);
  assign qprod = 61'(v_r) * 61'(MUL[30:0]);
  assign quo   = 30'(qprod >> (30 + L));

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= prod[59:30];
      x2_d_r <= x2_i;
      t_r    <= lstw_pkg::Q_ONE - 31'(quo);
      x2_o_r <= x2_d_r;
    end
  end

  assign t_o  = t_r;
  assign x2_o = x2_o_r;

endmodule

>>> hdl/lstw_sincos.sv
// ----------------------------------------------------------------------------
// lstw_sincos
// Pipelined sine and cosine of a 16-bit binary angle, signed Q30 results.
// ----------------------------------------------------------------------------
module lstw_sincos (
  input  logic             clk,
  input  logic             en,
  input  lstw_pkg::angle_t angle_i,
  output lstw_pkg::trig_t  sin_o,
  output lstw_pkg::trig_t  cos_o
);

  localparam int XD = 2 * lstw_pkg::SIN_CELLS;      // x wait for sine chain
  localparam int OD = 2 * lstw_pkg::COS_CELLS + 2;  // octant info wait

  logic [13:0] red_nxt;
  logic [2:0]  oct_a_r;
  logic [13:0] red_a_r;
  logic [46:0] xprod;
  logic [29:0] x_b_r;
  logic [59:0] sq;
  logic [29:0] x_c_r;
  logic [29:0] x2_c_r;
  logic [2:0]  oct_d_r [OD];
  logic [29:0] x_d_r [XD];
  logic [60:0] sprod;
  logic [30:0] s_r;
  logic [30:0] s_d_r;
  logic [30:0] s0;
  logic [30:0] c0;
  logic        sw;
  logic [1:0]  quad;
  lstw_pkg::trig_t sin_nxt;
  lstw_pkg::trig_t cos_nxt;
  lstw_pkg::trig_t sin_r;
  lstw_pkg::trig_t cos_r;

  logic [29:0] sin_x2 [lstw_pkg::SIN_CELLS+1];
  logic [30:0] sin_t  [lstw_pkg::SIN_CELLS+1];
  logic [29:0] cos_x2 [lstw_pkg::COS_CELLS+1];
  logic [30:0] cos_t  [lstw_pkg::COS_CELLS+1];

  // fold the quadrant remainder into the first octant
  always_comb begin
    if (angle_i[13:0] <= lstw_pkg::OCT_HALF) begin
      red_nxt = angle_i[13:0];
    end else begin
      red_nxt = 14'(lstw_pkg::OCT_FULL - 15'(angle_i[13:0]));
    end
  end

  assign xprod = 47'(red_a_r) * 47'(lstw_pkg::PI_Q31) + 47'd32768;
  assign sq    = 60'(x_b_r) * 60'(x_b_r);

  assign sin_x2[0] = x2_c_r;
  assign sin_t[0]  = lstw_pkg::Q_ONE;
  assign cos_x2[0] = x2_c_r;
  assign cos_t[0]  = lstw_pkg::Q_ONE;

  for (genvar g = 0; g < lstw_pkg::SIN_CELLS; g++) begin : g_sin
    lstw_horner_cell #(.K(lstw_pkg::SIN_DIV[g])) u_cell (
      .clk  (clk),
      .en   (en),
      .x2_i (sin_x2[g]),
      .t_i  (sin_t[g]),
      .x2_o (sin_x2[g+1]),
      .t_o  (sin_t[g+1])
    );
  end

  for (genvar g = 0; g < lstw_pkg::COS_CELLS; g++) begin : g_cos
    lstw_horner_cell #(.K(lstw_pkg::COS_DIV[g])) u_cell (
      .clk  (clk),
      .en   (en),
      .x2_i (cos_x2[g]),
      .t_i  (cos_t[g]),
      .x2_o (cos_x2[g+1]),
      .t_o  (cos_t[g+1])
    );
  end

  assign sprod = 61'(x_d_r[XD-1]) * 61'(sin_t[lstw_pkg::SIN_CELLS]);

  assign {sw, quad} = oct_d_r[OD-1];

  // past the octant midpoint the chains swap roles
  always_comb begin
    s0 = sw ? cos_t[lstw_pkg::COS_CELLS] : s_d_r;
    c0 = sw ? s_d_r : cos_t[lstw_pkg::COS_CELLS];
    case (quad)
      2'd0: begin
        sin_nxt = lstw_pkg::trig_t'({1'b0, s0});
        cos_nxt = lstw_pkg::trig_t'({1'b0, c0});
      end
      2'd1: begin
        sin_nxt = lstw_pkg::trig_t'({1'b0, c0});
        cos_nxt = -lstw_pkg::trig_t'({1'b0, s0});
      end
      2'd2: begin
        sin_nxt = -lstw_pkg::trig_t'({1'b0, s0});
        cos_nxt = -lstw_pkg::trig_t'({1'b0, c0});
      end
      default: begin
        sin_nxt = -lstw_pkg::trig_t'({1'b0, c0});
        cos_nxt = lstw_pkg::trig_t'({1'b0, s0});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oct_a_r <= {(angle_i[13:0] > lstw_pkg::OCT_HALF), angle_i[15:14]};
      red_a_r <= red_nxt;
      x_b_r   <= xprod[45:16];
      x_c_r   <= x_b_r;
      x2_c_r  <= sq[59:30];
      oct_d_r[0] <= oct_a_r;
      for (int i = 1; i < OD; i++) begin
        oct_d_r[i] <= oct_d_r[i-1];
      end
      x_d_r[0] <= x_c_r;
      for (int i = 1; i < XD; i++) begin
        x_d_r[i] <= x_d_r[i-1];
      end
      s_r   <= sprod[60:30];
      s_d_r <= s_r;
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

>>> verif/tb_lidar_scan_to_world_points.sv
// ----------------------------------------------------------------------------
// tb_lidar_scan_to_world_points
// Self-checking bench for the lidar range-to-world-point converter. Samples
// are streamed in with random gaps while the sink stalls at random. Each
// accepted sample is run through a bit-exact fixed-point model (octant
// reduction, Taylor sine/cosine, per-product rounding). The expected point is
// queued and compared field by field with the DUT output, in order. Register
// settings change between phases, only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_lidar_scan_to_world_points;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int EXTREME_ITEMS = 40;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 135;
  localparam int MODE_SPAN     = 45;

  // writes to these indexes must be dropped by the block
  localparam logic [lstw_pkg::CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [lstw_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [lstw_pkg::POS_W-1:0] x_mm;
    logic [lstw_pkg::POS_W-1:0] y_mm;
    logic [15:0]                filt_mm;
    logic [9:0]                 echo_idx;
  } world_point_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [lstw_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [lstw_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [lstw_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [lstw_pkg::POS_W-1:0]       cfg_data = '0;

  // predictor's copy of the register file
  logic [lstw_pkg::POS_W-1:0] cur_origin_x = '0;
  logic [lstw_pkg::POS_W-1:0] cur_origin_y = '0;
  logic [15:0]                cur_heading  = '0;
  logic [15:0]                cur_mount    = '0;
  logic [15:0]                cur_lever    = lstw_pkg::LEVER_RESET_MM;

  world_point_t pending_points[$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           sender_gaps_on = 1'b0;
  bit           sink_stalls_on = 1'b0;
  int           stall_left = 0;

  lidar_scan_to_world_points u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- fixed-point predictor ----------------

  function automatic longint unsigned taylor_cell(input longint unsigned t,
                                                  input longint unsigned x2, input int k);
    return 64'(lstw_pkg::Q_ONE) - ((x2 * t) >> 30) / longint'(k);
  endfunction

  // r in 0..8192, unsigned Q30 results
  function automatic void octant_sin_cos(input longint unsigned r,
                                         output longint unsigned s,
                                         output longint unsigned c);
    longint unsigned x, x2, t;
    x  = (r * 64'(lstw_pkg::PI_Q31) + 64'd32768) >> 16;
    x2 = (x * x) >> 30;
    t  = 64'(lstw_pkg::Q_ONE);
    for (int i = 0; i < lstw_pkg::SIN_CELLS; i++) t = taylor_cell(t, x2, lstw_pkg::SIN_DIV[i]);
    s = (x * t) >> 30;
    t = 64'(lstw_pkg::Q_ONE);
    for (int i = 0; i < lstw_pkg::COS_CELLS; i++) t = taylor_cell(t, x2, lstw_pkg::COS_DIV[i]);
    c = t;
  endfunction

  function automatic void turn_sin_cos(input logic [15:0] a, output longint s,
                                       output longint c);
    longint unsigned s0, c0;
    logic [13:0]     r;
    r = a[13:0];
    if (r <= lstw_pkg::OCT_HALF) octant_sin_cos(64'(r), s0, c0);
    else octant_sin_cos(64'(lstw_pkg::OCT_FULL) - 64'(r), c0, s0);
    case (a[15:14])
      2'd0: begin
        s = longint'(s0);
        c = longint'(c0);
      end
      2'd1: begin
        s = longint'(c0);
        c = -longint'(s0);
      end
      2'd2: begin
        s = -longint'(s0);
        c = -longint'(c0);
      end
      default: begin
        s = -longint'(c0);
        c = longint'(s0);
      end
    endcase
  endfunction

  // mm times signed Q30, nearest with ties toward +inf
  function automatic longint mm_scale(input logic [15:0] mag, input longint f);
    longint p;
    p = longint'({48'd0, mag}) * f + (longint'(1) <<< 29);
    return p >>> 30;
  endfunction

  function automatic world_point_t predict_point(input logic [15:0] rng_mm,
                                                 input logic no_return,
                                                 input logic [9:0] beam);
    world_point_t pt;
    logic [15:0]  fr, theta, phi;
    logic [9:0]   b;
    logic [63:0]  quot, sum_x, sum_y;
    longint       hs, hc, ps, pc;
    fr = (no_return || rng_mm < lstw_pkg::NEAR_LIMIT_MM) ? lstw_pkg::FAR_FILL_MM : rng_mm;
    b  = (beam > lstw_pkg::SCAN_POINTS - 1) ? 10'(lstw_pkg::SCAN_POINTS - 1) : beam;
    quot  = (64'(b) * 64'd65536 + 64'd540) / 64'd1080;
    theta = 16'(quot - 64'd24576);
    phi   = cur_heading + cur_mount + theta;
    turn_sin_cos(cur_heading, hs, hc);
    turn_sin_cos(phi, ps, pc);
    sum_x = 64'(cur_origin_x) + mm_scale(cur_lever, hc) + mm_scale(fr, pc);
    sum_y = 64'(cur_origin_y) + mm_scale(cur_lever, hs) + mm_scale(fr, ps);
    pt.x_mm     = sum_x[lstw_pkg::POS_W-1:0];
    pt.y_mm     = sum_y[lstw_pkg::POS_W-1:0];
    pt.filt_mm  = fr;
    pt.echo_idx = beam;
    return pt;
  endfunction

  // ---------------- idle pattern ----------------

  // mostly short, a few long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
      stall_left <= idle_length() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------- result checking ----------------

  task automatic check_field(input string label, input logic [lstw_pkg::POS_W-1:0] want,
                             input logic [lstw_pkg::POS_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    world_point_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.x_mm     = out_tdata[39:0];
      got.y_mm     = out_tdata[79:40];
      got.filt_mm  = out_tdata[95:80];
      got.echo_idx = out_tdata[105:96];
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_points.pop_front();
        check_field("point_x_mm", want.x_mm, got.x_mm);
        check_field("point_y_mm", want.y_mm, got.y_mm);
        check_field("filtered_range_mm", lstw_pkg::POS_W'(want.filt_mm),
                    lstw_pkg::POS_W'(got.filt_mm));
        check_field("echo_index", lstw_pkg::POS_W'(want.echo_idx),
                    lstw_pkg::POS_W'(got.echo_idx));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d points outstanding", $time, pending_points.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_sample(input logic [15:0] rng_mm, input logic no_return,
                             input logic [9:0] beam);
    logic [lstw_pkg::IN_TDATA_W-1:0] word;
    int                              gap;
    word = '0;
    word[15:0]  = rng_mm;
    word[25:16] = beam;
    gap = (sender_gaps_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= no_return;
    do @(posedge clk); while (!in_tready);
    pending_points.insert(pending_points.size(), predict_point(rng_mm, no_return, beam));
  endtask

  task automatic send_random_sample();
    logic [15:0] rng_mm;
    logic [9:0]  beam;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 10) rng_mm = 16'($urandom_range(0, 60));
    else if (r < 14) rng_mm = 16'($urandom_range(65500, 65535));
    else rng_mm = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 85) beam = 10'($urandom_range(0, lstw_pkg::SCAN_POINTS - 1));
    else if (r < 95) beam = 10'($urandom_range(lstw_pkg::SCAN_POINTS, 1023));
    else beam = ($urandom_range(0, 1) != 0) ? 10'(lstw_pkg::SCAN_POINTS - 1) : 10'd1023;
    send_sample(rng_mm, $urandom_range(0, 9) == 0, beam);
  endtask

  // drop valid, then hold until every queued point has come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need one assignment per edge
  task automatic write_reg(input logic [lstw_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lstw_pkg::POS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lstw_pkg::CFG_ORIGIN_X: cur_origin_x = value;
      lstw_pkg::CFG_ORIGIN_Y: cur_origin_y = value;
      lstw_pkg::CFG_HEADING:  cur_heading  = value[15:0];
      lstw_pkg::CFG_MOUNT:    cur_mount    = value[15:0];
      lstw_pkg::CFG_LEVER:    cur_lever    = value[15:0];
      default: ;
    endcase
  endtask

  // junk above bit 15 on the angle/lever writes must be masked off
  task automatic set_registers(input logic [lstw_pkg::POS_W-1:0] ox,
                               input logic [lstw_pkg::POS_W-1:0] oy,
                               input logic [15:0] hd, input logic [15:0] mt,
                               input logic [15:0] lv);
    wait_results_drained();
    write_reg(lstw_pkg::CFG_INDEX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
              {8'($urandom), 32'($urandom)});
    write_reg(lstw_pkg::CFG_ORIGIN_X, ox);
    write_reg(lstw_pkg::CFG_ORIGIN_Y, oy);
    write_reg(lstw_pkg::CFG_HEADING, {24'($urandom), hd});
    write_reg(lstw_pkg::CFG_MOUNT, {24'($urandom), mt});
    write_reg(lstw_pkg::CFG_LEVER, {24'($urandom), lv});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------- tests ----------------

  // reset register values, field extremes and the range filter edges
  task automatic test_directed_fields();
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    send_sample(16'd0, 1'b0, 10'd0);
    send_sample(16'd49, 1'b0, 10'd1);
    send_sample(16'd50, 1'b0, 10'd2);
    send_sample(16'd51, 1'b0, 10'd405);
    send_sample(16'd65535, 1'b0, 10'(lstw_pkg::SCAN_POINTS - 1));
    send_sample(16'd1234, 1'b1, 10'(lstw_pkg::SCAN_POINTS));
    send_sample(16'd0, 1'b1, 10'd1023);
    send_sample(16'd65535, 1'b1, 10'd512);
    send_sample(16'd25000, 1'b0, 10'd270);
    send_sample(16'd3000, 1'b0, 10'd540);
    send_sample(16'd100, 1'b0, 10'd3);
    send_sample(16'd50, 1'b0, 10'd809);
    send_sample(16'd7777, 1'b0, 10'd100);
    send_sample(16'd65535, 1'b0, 10'd0);
    send_sample(16'd49, 1'b0, 10'd1023);
    send_sample(16'd1, 1'b0, 10'(lstw_pkg::SCAN_POINTS));
    wait_results_drained();
  endtask

  // register extremes, position wraparound, octant boundary on heading
  task automatic test_register_extremes();
    sender_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    set_registers(40'h7F_FFFF_FFFF, 40'h80_0000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (EXTREME_ITEMS) send_random_sample();
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    set_registers(40'h80_0000_0000, 40'h7F_FFFF_FFFF, 16'h0000, 16'h0000, 16'h0000);
    repeat (EXTREME_ITEMS) send_random_sample();
    sink_stalls_on = 1'b0;
    set_registers(40'hFF_FFFF_FFFF, 40'h00_0000_0001, 16'(lstw_pkg::OCT_HALF),
                  16'(lstw_pkg::OCT_FULL), 16'd1);
    repeat (EXTREME_ITEMS) send_random_sample();
    wait_results_drained();
  endtask

  // random settings; idle modes switch within each phase
  task automatic test_random_settings();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_registers({8'($urandom), 32'($urandom)}, {8'($urandom), 32'($urandom)},
                    16'($urandom), 16'($urandom), 16'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % MODE_SPAN == 0) begin
          sender_gaps_on = 1'($urandom_range(0, 1));
          sink_stalls_on = 1'($urandom_range(0, 1));
        end
        // occasionally starve the pipe completely
        if ($urandom_range(0, 59) == 0) wait_results_drained();
        send_random_sample();
      end
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_fields();
    test_register_extremes();
    test_random_settings();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
